[sv/h2r_pkg.sv]
// ----------------------------------------------------------------------------
// h2r_pkg
// Shared types and constants for the HSV to RGB converter pipeline.
// ----------------------------------------------------------------------------
package h2r_pkg;

  localparam int unsigned HUE_W     = 9;
  localparam int unsigned PCT_W     = 7;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned SV_W      = 14;
  localparam int unsigned DIST_W    = 6;
  localparam int unsigned NUM_W     = 20;
  localparam int unsigned SCALED_W  = 28;
  localparam int unsigned PROD_W    = 57;

  localparam int unsigned HUE_MAX    = 360;
  localparam int unsigned PCT_MAX    = 100;
  localparam int unsigned SECTOR_DEG = 60;
  localparam int unsigned CHAN_MAX   = 255;
  localparam int unsigned BASE_SCALE = SECTOR_DEG * PCT_MAX;

  // floor(p / 600000) == (p * RECIP_M) >> RECIP_SHIFT for p < 2^28
  localparam int unsigned  RECIP_SHIFT = 48;
  localparam longint unsigned RECIP_M  = 64'd469124962;

  typedef enum logic [2:0] {
    SEC_RY, SEC_YG, SEC_GC, SEC_CB, SEC_BM, SEC_MR
  } sector_t;

  typedef enum logic [1:0] {
    TERM_C, TERM_X, TERM_ZERO
  } term_t;

  typedef struct packed {
    logic              err;
    logic [NUM_W-1:0]  base;
    logic [NUM_W-1:0]  px;
    logic [NUM_W-1:0]  pz;
    term_t             red_term;
    term_t             green_term;
    term_t             blue_term;
  } h2r_mid_t;

endpackage

[sv/h2r_front.sv]
// ----------------------------------------------------------------------------
// h2r_front
// Stages 1-2: range check, sector decode, S*V, then the three products
// 6000*V, S*V*d and S*V*60.
// ----------------------------------------------------------------------------
module h2r_front (
  input  logic                          clk,
  input  logic                          en1,
  input  logic                          en2,
  input  logic [h2r_pkg::HUE_W-1:0]     hue,
  input  logic [h2r_pkg::PCT_W-1:0]     sat,
  input  logic [h2r_pkg::PCT_W-1:0]     val,
  output h2r_pkg::h2r_mid_t             mid
);
  import h2r_pkg::*;

  logic              err_nxt, err_r;
  logic [SV_W-1:0]   sv_nxt, sv_r;
  logic [DIST_W-1:0] d_nxt, d_r;
  logic [PCT_W-1:0]  v_r;
  term_t             rt_nxt, gt_nxt, bt_nxt;
  term_t             rt_r, gt_r, bt_r;
  logic [HUE_W-1:0]  t;
  sector_t           sector;
  h2r_mid_t          mid_nxt, mid_r;

  always_comb begin
    err_nxt = (hue > HUE_W'(HUE_MAX)) || (sat > PCT_W'(PCT_MAX)) ||
              (val > PCT_W'(PCT_MAX));
    sv_nxt  = SV_W'(sat) * SV_W'(val);

    if (hue >= HUE_W'(360))      t = hue - HUE_W'(360);
    else if (hue >= HUE_W'(240)) t = hue - HUE_W'(240);
    else if (hue >= HUE_W'(120)) t = hue - HUE_W'(120);
    else                         t = hue;

    if (t >= HUE_W'(SECTOR_DEG)) d_nxt = DIST_W'(t - HUE_W'(SECTOR_DEG));
    else                         d_nxt = DIST_W'(HUE_W'(SECTOR_DEG) - t);

    if (hue >= HUE_W'(300))      sector = SEC_MR;
    else if (hue >= HUE_W'(240)) sector = SEC_BM;
    else if (hue >= HUE_W'(180)) sector = SEC_CB;
    else if (hue >= HUE_W'(120)) sector = SEC_GC;
    else if (hue >= HUE_W'(60))  sector = SEC_YG;
    else                         sector = SEC_RY;

    unique case (sector)
      SEC_RY:  begin rt_nxt = TERM_C;    gt_nxt = TERM_X;    bt_nxt = TERM_ZERO; end
      SEC_YG:  begin rt_nxt = TERM_X;    gt_nxt = TERM_C;    bt_nxt = TERM_ZERO; end
      SEC_GC:  begin rt_nxt = TERM_ZERO; gt_nxt = TERM_C;    bt_nxt = TERM_X;    end
      SEC_CB:  begin rt_nxt = TERM_ZERO; gt_nxt = TERM_X;    bt_nxt = TERM_C;    end
      SEC_BM:  begin rt_nxt = TERM_X;    gt_nxt = TERM_ZERO; bt_nxt = TERM_C;    end
      default: begin rt_nxt = TERM_C;    gt_nxt = TERM_ZERO; bt_nxt = TERM_X;    end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      err_r <= err_nxt;
      sv_r  <= sv_nxt;
      d_r   <= d_nxt;
      v_r   <= val;
      rt_r  <= rt_nxt;
      gt_r  <= gt_nxt;
      bt_r  <= bt_nxt;
    end
  end

  always_comb begin
    mid_nxt.err        = err_r;
    mid_nxt.base       = NUM_W'(v_r) * NUM_W'(BASE_SCALE);
    mid_nxt.px         = NUM_W'(sv_r) * NUM_W'(d_r);
    mid_nxt.pz         = NUM_W'(sv_r) * NUM_W'(SECTOR_DEG);
    mid_nxt.red_term   = rt_r;
    mid_nxt.green_term = gt_r;
    mid_nxt.blue_term  = bt_r;
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      mid_r <= mid_nxt;
    end
  end

  assign mid = mid_r;

endmodule

[sv/h2r_chan.sv]
// ----------------------------------------------------------------------------
// h2r_chan
// Stages 3-4 of one channel: numerator select and scale by 255, then
// division by 600000 through a reciprocal multiply.
// ----------------------------------------------------------------------------
module h2r_chan (
  input  logic                          clk,
  input  logic                          en3,
  input  logic                          en4,
  input  h2r_pkg::h2r_mid_t             mid,
  input  h2r_pkg::term_t                term,
  output logic [h2r_pkg::CHAN_W-1:0]    chan
);
  import h2r_pkg::*;

  logic [NUM_W-1:0]    num;
  logic [SCALED_W-1:0] scaled_nxt, scaled_r;
  logic [PROD_W-1:0]   prod;
  logic [CHAN_W-1:0]   chan_nxt, chan_r;

  always_comb begin
    case (term)
      TERM_C:  num = mid.base;
      TERM_X:  num = mid.base - mid.px;
      default: num = mid.base - mid.pz;
    endcase
    if (mid.err) num = '0;
    scaled_nxt = SCALED_W'(num) * SCALED_W'(CHAN_MAX);
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      scaled_r <= scaled_nxt;
    end
  end

  assign prod     = PROD_W'(scaled_r) * PROD_W'(RECIP_M);
  assign chan_nxt = prod[RECIP_SHIFT +: CHAN_W];

  always_ff @(posedge clk) begin
    if (en4) begin
      chan_r <= chan_nxt;
    end
  end

  assign chan = chan_r;

endmodule

[sv/hsv_to_rgb_converter.sv]
// ----------------------------------------------------------------------------
// Each input transfer passes the stage 1, 2, 3 and 4 registers before result valid.
// Throughput: one transfer per cycle; each stage holds when the one after
// it is full and stalled, so bubbles close up under back-pressure.
// Reset (rst_n low, synchronous) empties the pipeline; data regs keep state.
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Four-stage HSV to 8-bit RGB converter with range check.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [h2r_pkg::HUE_W-1:0]     in_hue_degrees,
  input  logic [h2r_pkg::PCT_W-1:0]     in_saturation_pct,
  input  logic [h2r_pkg::PCT_W-1:0]     in_value_pct,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [h2r_pkg::CHAN_W-1:0]    out_red,
  output logic [h2r_pkg::CHAN_W-1:0]    out_green,
  output logic [h2r_pkg::CHAN_W-1:0]    out_blue,
  output logic                          out_range_error
);
  import h2r_pkg::*;

  logic [3:0] vld_r, vld_nxt;
  logic [3:0] rdy;
  logic       err3_r, err4_r;
  h2r_mid_t   mid;

  always_comb begin
    rdy[3] = !vld_r[3] || !out_stall;
    rdy[2] = !vld_r[2] || rdy[3];
    rdy[1] = !vld_r[1] || rdy[2];
    rdy[0] = !vld_r[0] || rdy[1];
    vld_nxt[0] = rdy[0] ? in_valid : vld_r[0];
    vld_nxt[1] = rdy[1] ? vld_r[0] : vld_r[1];
    vld_nxt[2] = rdy[2] ? vld_r[1] : vld_r[2];
    vld_nxt[3] = rdy[3] ? vld_r[2] : vld_r[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) err3_r <= mid.err;
    if (rdy[3]) err4_r <= err3_r;
  end

  h2r_front u_front (
    .clk (clk),
    .en1 (rdy[0]),
    .en2 (rdy[1]),
    .hue (in_hue_degrees),
    .sat (in_saturation_pct),
    .val (in_value_pct),
    .mid (mid)
  );

  h2r_chan u_red (
    .clk  (clk),
    .en3  (rdy[2]),
    .en4  (rdy[3]),
    .mid  (mid),
    .term (mid.red_term),
    .chan (out_red)
  );

  h2r_chan u_green (
    .clk  (clk),
    .en3  (rdy[2]),
    .en4  (rdy[3]),
    .mid  (mid),
    .term (mid.green_term),
    .chan (out_green)
  );

  h2r_chan u_blue (
    .clk  (clk),
    .en3  (rdy[2]),
    .en4  (rdy[3]),
    .mid  (mid),
    .term (mid.blue_term),
    .chan (out_blue)
  );

  assign in_stall        = !rdy[0];
  assign out_valid       = vld_r[3];
  assign out_range_error = err4_r;

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks hsv_to_rgb_converter: a directed table of corner colors, then random
// HSV triples, under random valid and stall gaps with gap-free stretches. Each
// result is checked against a typed-in color or an integer converter model.
// ----------------------------------------------------------------------------
module testbench;
  import h2r_pkg::*;

  localparam longint unsigned DENOM = BASE_SCALE * PCT_MAX;
  localparam int RANDOM_ITEMS = 950;
  localparam int DRAIN_AT     = 470;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int TAB_LEN      = 24;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              err;
  } color_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] sat;
    logic [PCT_W-1:0] val;
    logic             known;
    color_t           rgb;
  } stim_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [HUE_W-1:0]    in_hue_degrees;
  logic [PCT_W-1:0]    in_saturation_pct;
  logic [PCT_W-1:0]    in_value_pct;
  logic                out_valid;
  logic                out_stall;
  logic [CHAN_W-1:0]   out_red;
  logic [CHAN_W-1:0]   out_green;
  logic [CHAN_W-1:0]   out_blue;
  logic                out_range_error;

  color_t color_q[$];
  int     mismatches;
  int     cycles;

  // known = 1: expected color typed in, else taken from hsv_color()
  stim_row_t corner_tab [TAB_LEN] = '{
    '{9'd0,   7'd0,   7'd0,   1'b1, '{8'd0,   8'd0,   8'd0,   1'b0}},
    '{9'd0,   7'd100, 7'd100, 1'b1, '{8'd255, 8'd0,   8'd0,   1'b0}},
    '{9'd120, 7'd100, 7'd100, 1'b1, '{8'd0,   8'd255, 8'd0,   1'b0}},
    '{9'd240, 7'd100, 7'd100, 1'b1, '{8'd0,   8'd0,   8'd255, 1'b0}},
    '{9'd360, 7'd100, 7'd100, 1'b1, '{8'd255, 8'd0,   8'd0,   1'b0}},
    '{9'd200, 7'd0,   7'd100, 1'b1, '{8'd255, 8'd255, 8'd255, 1'b0}},
    '{9'd360, 7'd0,   7'd0,   1'b1, '{8'd0,   8'd0,   8'd0,   1'b0}},
    '{9'd361, 7'd50,  7'd50,  1'b1, '{8'd0,   8'd0,   8'd0,   1'b1}},
    '{9'd511, 7'd127, 7'd127, 1'b1, '{8'd0,   8'd0,   8'd0,   1'b1}},
    '{9'd0,   7'd101, 7'd0,   1'b1, '{8'd0,   8'd0,   8'd0,   1'b1}},
    '{9'd100, 7'd0,   7'd101, 1'b1, '{8'd0,   8'd0,   8'd0,   1'b1}},
    '{9'd360, 7'd100, 7'd101, 1'b1, '{8'd0,   8'd0,   8'd0,   1'b1}},
    '{9'd360, 7'd101, 7'd100, 1'b1, '{8'd0,   8'd0,   8'd0,   1'b1}},
    '{9'd0,   7'd127, 7'd0,   1'b1, '{8'd0,   8'd0,   8'd0,   1'b1}},
    '{9'd60,  7'd100, 7'd100, 1'b0, '0},
    '{9'd30,  7'd100, 7'd100, 1'b0, '0},
    '{9'd90,  7'd75,  7'd80,  1'b0, '0},
    '{9'd180, 7'd100, 7'd100, 1'b0, '0},
    '{9'd299, 7'd37,  7'd63,  1'b0, '0},
    '{9'd300, 7'd100, 7'd100, 1'b0, '0},
    '{9'd359, 7'd100, 7'd100, 1'b0, '0},
    '{9'd59,  7'd1,   7'd99,  1'b0, '0},
    '{9'd300, 7'd100, 7'd1,   1'b0, '0},
    '{9'd255, 7'd64,  7'd64,  1'b0, '0}
  };

  hsv_to_rgb_converter dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_hue_degrees    (in_hue_degrees),
    .in_saturation_pct (in_saturation_pct),
    .in_value_pct      (in_value_pct),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_red           (out_red),
    .out_green         (out_green),
    .out_blue          (out_blue),
    .out_range_error   (out_range_error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [CHAN_W-1:0] channel_of(longint unsigned num);
    longint unsigned q;
    q = (num * CHAN_MAX) / DENOM;
    return (q > CHAN_MAX) ? CHAN_MAX[CHAN_W-1:0] : q[CHAN_W-1:0];
  endfunction

  function automatic color_t hsv_color(logic [HUE_W-1:0] hue, logic [PCT_W-1:0] sat,
                                       logic [PCT_W-1:0] val);
    longint unsigned h, s, v, chroma, xcomp, offs, t, hdist, rn, gn, bn;
    sector_t sec;
    color_t o;
    h = hue;
    s = sat;
    v = val;
    o = '0;
    if (h > HUE_MAX || s > PCT_MAX || v > PCT_MAX) begin
      o.err = 1'b1;
      return o;
    end
    chroma = SECTOR_DEG * s * v;
    t = h % (2 * SECTOR_DEG);
    hdist = (t >= SECTOR_DEG) ? (t - SECTOR_DEG) : (SECTOR_DEG - t);
    xcomp = s * v * (SECTOR_DEG - hdist);
    offs = BASE_SCALE * v - chroma;
    // hue of exactly 360 folds into the last sector
    sec = (h >= HUE_MAX) ? SEC_MR : sector_t'(h / SECTOR_DEG);
    case (sec)
      SEC_RY: begin rn = chroma; gn = xcomp;  bn = 0;      end
      SEC_YG: begin rn = xcomp;  gn = chroma; bn = 0;      end
      SEC_GC: begin rn = 0;      gn = chroma; bn = xcomp;  end
      SEC_CB: begin rn = 0;      gn = xcomp;  bn = chroma; end
      SEC_BM: begin rn = xcomp;  gn = 0;      bn = chroma; end
      default: begin rn = chroma; gn = 0;     bn = xcomp;  end
    endcase
    o.red   = channel_of(rn + offs);
    o.green = channel_of(gn + offs);
    o.blue  = channel_of(bn + offs);
    return o;
  endfunction

  task automatic send_color(logic [HUE_W-1:0] hue, logic [PCT_W-1:0] sat,
                            logic [PCT_W-1:0] val, logic known, color_t typed,
                            bit steady, bit drain);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (drain) begin
      @(negedge clk);
      in_valid <= 1'b0;
      while (color_q.size() != 0) @(posedge clk);
    end
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid          <= 1'b1;
    in_hue_degrees    <= hue;
    in_saturation_pct <= sat;
    in_value_pct      <= val;
    do @(posedge clk); while (in_stall);
    color_q.push_back(known ? typed : hsv_color(hue, sat, val));
  endtask

  // sender
  initial begin
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] sat, val;
    int sel;
    in_valid          = 1'b0;
    in_hue_degrees    = '0;
    in_saturation_pct = '0;
    in_value_pct      = '0;
    rst_n             = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < TAB_LEN; i++) begin
      send_color(corner_tab[i].hue, corner_tab[i].sat, corner_tab[i].val,
                 corner_tab[i].known, corner_tab[i].rgb, (i / 8) % 2 == 1, 1'b0);
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 80) begin
        hue = HUE_W'($urandom_range(0, HUE_MAX));
        sat = PCT_W'($urandom_range(0, PCT_MAX));
        val = PCT_W'($urandom_range(0, PCT_MAX));
      end else if (sel < 90) begin
        hue = HUE_W'($urandom_range(0, 511));
        sat = PCT_W'($urandom_range(0, 127));
        val = PCT_W'($urandom_range(0, 127));
      end else begin
        // sector edges at full or no saturation, full or random value
        hue = HUE_W'($urandom_range(0, 6) * SECTOR_DEG);
        if (hue != 0 && $urandom_range(0, 1)) hue = hue - HUE_W'(1);
        sat = PCT_W'($urandom_range(0, 1) * PCT_MAX);
        val = $urandom_range(0, 1) ? PCT_W'(PCT_MAX) : PCT_W'($urandom_range(0, PCT_MAX));
      end
      send_color(hue, sat, val, 1'b0, '0, (i / 64) % 3 == 1, i == DRAIN_AT);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (color_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (color_q.size() != 0) mismatches++;
    if (mismatches == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

  // receiver stall pattern
  initial begin
    int wait_n;
    int n;
    n = 0;
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      wait_n = ((n / 50) % 3 == 2) ? 0 : $urandom_range(0, 5);
      repeat (wait_n) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      n++;
    end
  end

  // result check
  always @(posedge clk) begin
    color_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_red, out_green, out_blue, out_range_error};
      if (color_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer: %p", got);
      end else begin
        want = color_q.pop_front();
        if (got.red !== want.red || got.green !== want.green ||
            got.blue !== want.blue || got.err !== want.err) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: rgb %0d %0d %0d err %0d, expected %0d %0d %0d err %0d",
                     got.red, got.green, got.blue, got.err,
                     want.red, want.green, want.blue, want.err);
        end
      end
    end
  end

  initial cycles = 0;
  initial mismatches = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

endmodule
